### rtl/core/case_insensitive_edit_distance_top_assert.svh
// ----------------------------------------------------------------------------
// case_insensitive_edit_distance_top_assert.svh
// assertion macros shared by the edit distance checker
// ----------------------------------------------------------------------------
`ifndef CASE_INSENSITIVE_EDIT_DISTANCE_TOP_ASSERT_SVH
`define CASE_INSENSITIVE_EDIT_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define CED_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define CED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, live during reset
`define CED_ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg
// shared constants, types and helpers of the edit distance block
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int MAX_LEN = 128;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int COST_W  = LEN_W;
  localparam int SYM_W   = 8;
  localparam int OP_W    = 2;
  localparam int DIST_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SCAN   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  function automatic logic [SYM_W-1:0] fold_case(input logic [SYM_W-1:0] c);
    logic [SYM_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  function automatic logic [COST_W-1:0] min3(input logic [COST_W-1:0] a,
                                             input logic [COST_W-1:0] b,
                                             input logic [COST_W-1:0] c);
    logic [COST_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

### rtl/core/case_insensitive_edit_distance_top.sv
// ----------------------------------------------------------------------------
// case_insensitive_edit_distance_top
// case-insensitive levenshtein distance over two streamed byte strings
// ----------------------------------------------------------------------------
// the first string and one cost row live in two synchronous rams of MAX_LEN
// entries; row entry zero is the second-string length held in a register.
// an append item writes both rams. a second-string item walks the row ram
// across every first-string byte, since the row ram is read and written back
// one entry per cycle. a finish item reads the ram, then loads the output
// register once an earlier result no longer waits in the output register;
// its own result may then wait there while the next items are taken. bytes
// past MAX_LEN or first-string bytes after the second string has started
// are dropped and flagged on the result.
module case_insensitive_edit_distance_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // symbol[7:0]
  input  logic [1:0] s_axis_tuser,   // operation[1:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // distance[7:0]
  output logic       m_axis_tuser    // input_error
);
  import ced_pkg::*;

  logic              fs_we;
  logic [SYM_W-1:0]  fs_wdata;
  logic [SYM_W-1:0]  fs_rdata;
  logic              cr_we;
  logic [COST_W-1:0] cr_wdata;
  logic [COST_W-1:0] cr_rdata;
  logic [IDX_W-1:0]  waddr;
  logic              re;
  logic [IDX_W-1:0]  raddr;

  ced_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_op     (s_axis_tuser),
    .s_sym    (s_axis_tdata),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_dist   (m_axis_tdata),
    .m_err    (m_axis_tuser),
    .fs_we    (fs_we),
    .fs_wdata (fs_wdata),
    .fs_rdata (fs_rdata),
    .cr_we    (cr_we),
    .cr_wdata (cr_wdata),
    .cr_rdata (cr_rdata),
    .waddr    (waddr),
    .re       (re),
    .raddr    (raddr)
  );

  ced_ram #(.ADDR_W(IDX_W), .DATA_W(SYM_W)) u_first_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (waddr),
    .wdata (fs_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (fs_rdata)
  );

  ced_ram #(.ADDR_W(IDX_W), .DATA_W(COST_W)) u_row_ram (
    .clk   (clk),
    .we    (cr_we),
    .waddr (waddr),
    .wdata (cr_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (cr_rdata)
  );

endmodule

### rtl/core/ced_ram.sv
// ----------------------------------------------------------------------------
// ced_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ced_ram #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/ced_ctrl.sv
// ----------------------------------------------------------------------------
// ced_ctrl
// sequencer and cost cell: walks the cost row once per second-string byte
// ----------------------------------------------------------------------------
module ced_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_valid,
  output logic                       s_ready,
  input  logic [ced_pkg::OP_W-1:0]   s_op,
  input  logic [ced_pkg::SYM_W-1:0]  s_sym,
  output logic                       m_valid,
  input  logic                       m_ready,
  output logic [ced_pkg::DIST_W-1:0] m_dist,
  output logic                       m_err,
  output logic                       fs_we,
  output logic [ced_pkg::SYM_W-1:0]  fs_wdata,
  input  logic [ced_pkg::SYM_W-1:0]  fs_rdata,
  output logic                       cr_we,
  output logic [ced_pkg::COST_W-1:0] cr_wdata,
  input  logic [ced_pkg::COST_W-1:0] cr_rdata,
  output logic [ced_pkg::IDX_W-1:0]  waddr,
  output logic                       re,
  output logic [ced_pkg::IDX_W-1:0]  raddr
);
  import ced_pkg::*;

  state_t            state, state_next;
  logic [LEN_W-1:0]  first_len, first_len_next;
  logic [LEN_W-1:0]  second_len, second_len_next;
  logic              err, err_next;
  logic [LEN_W-1:0]  idx, idx_next;
  logic [LEN_W-1:0]  idx_inc;
  logic [COST_W-1:0] diag, diag_next;
  logic [COST_W-1:0] left, left_next;
  logic [SYM_W-1:0]  sym_q, sym_next;
  logic              use_len, use_len_next;
  logic [LEN_W-1:0]  len_q, len_q_next;
  logic              err_q, err_q_next;
  logic              load_out;
  logic              accept;
  logic [SYM_W-1:0]  sym_fold;
  logic [COST_W-1:0] cost_next;
  logic [LEN_W-1:0]  second_inc;

  assign sym_fold   = fold_case(s_sym);
  assign idx_inc    = idx + LEN_W'(1);
  assign second_inc = second_len + LEN_W'(1);
  assign cost_next  = (fs_rdata == sym_q) ? diag
                    : min3(cr_rdata, left, diag) + COST_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      first_len  <= '0;
      second_len <= '0;
      err        <= 1'b0;
    end else begin
      state      <= state_next;
      first_len  <= first_len_next;
      second_len <= second_len_next;
      err        <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    diag    <= diag_next;
    left    <= left_next;
    sym_q   <= sym_next;
    use_len <= use_len_next;
    len_q   <= len_q_next;
    err_q   <= err_q_next;
  end

  always_comb begin
    state_next      = state;
    first_len_next  = first_len;
    second_len_next = second_len;
    err_next        = err;
    idx_next        = idx;
    diag_next       = diag;
    left_next       = left;
    sym_next        = sym_q;
    use_len_next    = use_len;
    len_q_next      = len_q;
    err_q_next      = err_q;
    s_ready         = 1'b0;
    accept          = 1'b0;
    load_out        = 1'b0;
    fs_we           = 1'b0;
    fs_wdata        = sym_fold;
    cr_we           = 1'b0;
    cr_wdata        = cost_next;
    waddr           = idx[IDX_W-1:0];
    re              = 1'b0;
    raddr           = '0;
    unique case (state)
      ST_IDLE: begin
        s_ready = 1'b1;
        accept  = s_valid;
        if (accept) begin
          unique case (op_t'(s_op))
            OP_APPEND: begin
              if (second_len != '0 || first_len == LEN_W'(MAX_LEN)) begin
                err_next = 1'b1;
              end else begin
                fs_we          = 1'b1;
                cr_we          = 1'b1;
                waddr          = first_len[IDX_W-1:0];
                cr_wdata       = COST_W'(first_len + LEN_W'(1));
                first_len_next = first_len + LEN_W'(1);
              end
            end
            OP_SCAN: begin
              if (second_len == LEN_W'(MAX_LEN)) begin
                err_next = 1'b1;
              end else begin
                second_len_next = second_inc;
                diag_next       = COST_W'(second_len);
                left_next       = COST_W'(second_inc);
                sym_next        = sym_fold;
                idx_next        = '0;
                if (first_len != '0) begin
                  re         = 1'b1;
                  raddr      = '0;
                  state_next = ST_SCAN;
                end
              end
            end
            OP_FINISH: begin
              use_len_next    = (first_len == '0);
              len_q_next      = second_len;
              err_q_next      = err;
              re              = (first_len != '0);
              raddr           = IDX_W'(first_len - LEN_W'(1));
              first_len_next  = '0;
              second_len_next = '0;
              err_next        = 1'b0;
              state_next      = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cr_we     = 1'b1;
        waddr     = idx[IDX_W-1:0];
        diag_next = cr_rdata;
        left_next = cost_next;
        idx_next  = idx_inc;
        if (idx_inc == first_len) begin
          state_next = ST_IDLE;
        end else begin
          re    = 1'b1;
          raddr = idx_inc[IDX_W-1:0];
        end
      end
      ST_EMIT: begin
        if (!m_valid || m_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load_out) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_dist <= use_len ? DIST_W'(len_q) : DIST_W'(cr_rdata);
      m_err  <= err_q;
    end
  end

endmodule

### rtl/core/ced_checker.sv
// ----------------------------------------------------------------------------
// ced_checker
// port-level checks of the edit distance block, bound to the top level
// ----------------------------------------------------------------------------
`include "case_insensitive_edit_distance_top_assert.svh"

module ced_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [1:0] s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);
  import ced_pkg::*;

  logic finish_taken;

  assign finish_taken = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_FINISH);

  `CED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                   "result dropped or changed while stalled")
  `CED_ASSERT_NEXT_RAW(a_rst_clear, rst, !m_axis_tvalid, "result valid right after reset")
  `CED_ASSERT_NEXT(a_finish_busy, finish_taken, !s_axis_tready,
                   "item taken during result fetch")
  `CED_ASSERT_SAME(a_dist_range, m_axis_tvalid, m_axis_tdata <= DIST_W'(MAX_LEN),
                   "distance out of range")

endmodule

bind case_insensitive_edit_distance_top ced_checker u_ced_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
